@@ rtl/pcm_to_pwm_sample_formatter_core_defines.svh @@
// ----------------------------------------------------------------------------
// pcm to pwm sample formatter assertion macros
// shared concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef PCM_TO_PWM_SAMPLE_FORMATTER_CORE_DEFINES_SVH
`define PCM_TO_PWM_SAMPLE_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define P2PWM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p2pwm check failed");

// next-cycle implication
`define P2PWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p2pwm check failed");

`endif

@@ rtl/p2pwm_pkg.sv @@
// ----------------------------------------------------------------------------
// p2pwm_pkg
// shared widths, register indexes and types of the pcm to pwm formatter
// ----------------------------------------------------------------------------
package p2pwm_pkg;

    localparam int RANGE_SEARCH_TOP_DEF = 16;

    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 16;
    localparam int DUTY_W      = 14;
    localparam int RANGE_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_RANGE    = 2'd2;

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP       = 16'h8000;
    localparam logic [RANGE_W-1:0]  RESET_PWM_RANGE = 16'd1024;

    // power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic wide;
        logic stereo;
    } mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                wide;
        logic                stereo;
        logic                emit;
    } sample_item_t;

endpackage

@@ rtl/p2pwm_front.sv @@
// ----------------------------------------------------------------------------
// p2pwm_front
// byte assembler: tracks frame phase, joins 16-bit samples, tags each sample
// ----------------------------------------------------------------------------
module p2pwm_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  p2pwm_pkg::mode_t                  mode,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [p2pwm_pkg::BYTE_W-1:0]      data_byte,
    input  logic                              end_of_data,
    input  logic                              queue_full,
    output logic                              push,
    output p2pwm_pkg::sample_item_t           item
);

    logic [1:0]                         phase_reg;
    logic [1:0]                         phase_next;
    logic [p2pwm_pkg::BYTE_W-1:0]       low_hold_reg;
    logic [p2pwm_pkg::BYTE_W-1:0]       low_hold_next;
    logic [2:0]                         frame_len;
    logic [1:0]                         phase_eff;
    logic [2:0]                         phase_inc;
    logic                               is_low;
    logic                               accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        case ({mode.wide, mode.stereo})
            2'b00:   frame_len = 3'd1;
            2'b01:   frame_len = 3'd2;
            2'b10:   frame_len = 3'd2;
            default: frame_len = 3'd4;
        endcase

        phase_eff = ({1'b0, phase_reg} >= frame_len) ? 2'd0 : phase_reg;
        is_low    = mode.wide && !phase_eff[0];
        phase_inc = {1'b0, phase_eff} + 3'd1;

        item.wide   = mode.wide;
        item.stereo = mode.stereo;
        item.emit   = (phase_inc == frame_len);
        if (mode.wide)
            item.value = {data_byte, low_hold_reg} + p2pwm_pkg::SIGN_FLIP;
        else
            item.value = {{(p2pwm_pkg::SAMPLE_W - p2pwm_pkg::BYTE_W){1'b0}}, data_byte};

        push = accept && !is_low;

        phase_next    = phase_reg;
        low_hold_next = low_hold_reg;
        if (accept)
        begin
            if (is_low)
                low_hold_next = data_byte;
            if (phase_inc >= frame_len || end_of_data)
                phase_next = 2'd0;
            else
                phase_next = phase_inc[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 2'd0;
            low_hold_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            low_hold_reg <= low_hold_next;
        end
    end

endmodule

@@ rtl/p2pwm_queue.sv @@
// ----------------------------------------------------------------------------
// p2pwm_queue
// short sample queue decoupling the byte assembler from the scaler
// ----------------------------------------------------------------------------
module p2pwm_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  p2pwm_pkg::sample_item_t           push_item,
    input  logic                              pop,
    output p2pwm_pkg::sample_item_t           head_item,
    output logic                              empty,
    output logic                              full
);

    p2pwm_pkg::sample_item_t                  mem [p2pwm_pkg::QUEUE_DEPTH];
    logic [p2pwm_pkg::QUEUE_PTR_W-1:0]        wr_ptr_reg;
    logic [p2pwm_pkg::QUEUE_PTR_W-1:0]        rd_ptr_reg;
    logic [p2pwm_pkg::QUEUE_CNT_W-1:0]        count_reg;
    logic [p2pwm_pkg::QUEUE_CNT_W-1:0]        count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == p2pwm_pkg::QUEUE_CNT_W'(p2pwm_pkg::QUEUE_DEPTH));
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/p2pwm_back.sv @@
// ----------------------------------------------------------------------------
// p2pwm_back
// scaler: range bit encode, shift to duty width, left hold and output register
// ----------------------------------------------------------------------------
module p2pwm_back
#(
    parameter int RANGE_SEARCH_TOP = p2pwm_pkg::RANGE_SEARCH_TOP_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [p2pwm_pkg::RANGE_W-1:0]     pwm_range,
    input  p2pwm_pkg::sample_item_t           head_item,
    input  logic                              queue_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [p2pwm_pkg::DUTY_W-1:0]      left_duty,
    output logic [p2pwm_pkg::DUTY_W-1:0]      right_duty
);

    localparam int RB_W = $clog2(RANGE_SEARCH_TOP - 1);

    logic [RB_W-1:0]                    rb;
    logic [4:0]                         rb5;
    logic [p2pwm_pkg::SAMPLE_W-1:0]     shifted;
    logic [p2pwm_pkg::SAMPLE_W-1:0]     narrow_ext;
    logic [p2pwm_pkg::DUTY_W-1:0]       scaled;
    logic [p2pwm_pkg::DUTY_W-1:0]       left_hold_reg;
    logic [p2pwm_pkg::DUTY_W-1:0]       left_duty_reg;
    logic [p2pwm_pkg::DUTY_W-1:0]       right_duty_reg;
    logic                               out_valid_reg;
    logic                               slot_free;

    // smallest c with range below 2^c gives c-1
    always_comb
    begin
        rb = '0;
        for (int c = RANGE_SEARCH_TOP - 1; c >= 2; c--)
        begin
            if ({16'd0, pwm_range} < (32'd1 << c))
                rb = RB_W'(c - 1);
        end
    end

    assign rb5        = 5'(rb);
    assign narrow_ext = {{(p2pwm_pkg::SAMPLE_W - p2pwm_pkg::BYTE_W){1'b0}},
                         head_item.value[p2pwm_pkg::BYTE_W-1:0]};

    always_comb
    begin
        if (head_item.wide)
            shifted = head_item.value >> (5'd16 - rb5);
        else if (rb5 <= 5'd8)
            shifted = narrow_ext >> (5'd8 - rb5);
        else
            shifted = narrow_ext << (rb5 - 5'd8);
        scaled = shifted[p2pwm_pkg::DUTY_W-1:0];
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = !queue_empty && (!head_item.emit || slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_hold_reg <= '0;
        end
        else
        begin
            if (pop && head_item.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (pop && !head_item.emit)
                left_hold_reg <= scaled;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_item.emit)
        begin
            left_duty_reg  <= head_item.stereo ? left_hold_reg : scaled;
            right_duty_reg <= scaled;
        end
    end

    assign out_valid  = out_valid_reg;
    assign left_duty  = left_duty_reg;
    assign right_duty = right_duty_reg;

endmodule

@@ rtl/pcm_to_pwm_sample_formatter_core.sv @@
// ----------------------------------------------------------------------------
// pcm_to_pwm_sample_formatter_core
// pcm byte stream in, one left/right pwm duty pair per complete frame out
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with data_byte and end_of_data, one byte
//   per accepted word; end_of_data drops any partial frame after that byte
// output channel: out_valid/out_stall with left_duty and right_duty
// config channel: cfg_valid/cfg_ready, cfg_index selects sample width,
//   stereo mode or pwm range; cfg_ready is always high, write only when idle
// throughput: one byte per cycle sustained while out_stall is low, one result
//   per 1, 2 or 4 bytes depending on mode; the two-entry sample queue sets
//   the stall point; the byte that completes a frame is pushed into that queue
//   and its result enters the output register when it is popped
// out_stall holds the output register; the queue keeps absorbing samples
//   and in_stall rises only when both queue entries are occupied
// reset: frame phase and held bytes clear, queue empties, out_valid drops,
//   registers return to 16-bit stereo with range 1024
// ----------------------------------------------------------------------------
module pcm_to_pwm_sample_formatter_core
#(
    parameter int RANGE_SEARCH_TOP = p2pwm_pkg::RANGE_SEARCH_TOP_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [p2pwm_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                 end_of_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [p2pwm_pkg::DUTY_W-1:0]         left_duty,
    output logic [p2pwm_pkg::DUTY_W-1:0]         right_duty,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [p2pwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [p2pwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                               sample_width_reg;
    logic                               stereo_reg;
    logic [p2pwm_pkg::RANGE_W-1:0]      pwm_range_reg;
    p2pwm_pkg::mode_t                   mode;
    p2pwm_pkg::sample_item_t            push_item;
    p2pwm_pkg::sample_item_t            head_item;
    logic                               push;
    logic                               pop;
    logic                               queue_empty;
    logic                               queue_full;
    logic                               cfg_write;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign mode.wide   = sample_width_reg;
    assign mode.stereo = stereo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_width_reg <= 1'b1;
            stereo_reg       <= 1'b1;
            pwm_range_reg    <= p2pwm_pkg::RESET_PWM_RANGE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                p2pwm_pkg::REG_SAMPLE_WIDTH: sample_width_reg <= cfg_data[0];
                p2pwm_pkg::REG_STEREO:       stereo_reg       <= cfg_data[0];
                p2pwm_pkg::REG_PWM_RANGE:    pwm_range_reg    <= cfg_data;
                default:                     ;
            endcase
        end
    end

    p2pwm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .queue_full  (queue_full),
        .push        (push),
        .item        (push_item)
    );

    p2pwm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    p2pwm_back
    #(
        .RANGE_SEARCH_TOP (RANGE_SEARCH_TOP)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pwm_range   (pwm_range_reg),
        .head_item   (head_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_duty   (left_duty),
        .right_duty  (right_duty)
    );

endmodule

@@ rtl/p2pwm_checker.sv @@
// ----------------------------------------------------------------------------
// p2pwm_checker
// port-level checks of the pcm to pwm formatter, bound to the top level
// ----------------------------------------------------------------------------
`include "pcm_to_pwm_sample_formatter_core_defines.svh"

module p2pwm_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [p2pwm_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                 end_of_data,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [p2pwm_pkg::DUTY_W-1:0]         left_duty,
    input  logic [p2pwm_pkg::DUTY_W-1:0]         right_duty,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [p2pwm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [p2pwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                                   wide_trk_reg;
    logic                                   stereo_trk_reg;
    logic                                   big_range_trk_reg;
    logic                                   cfg_write;
    logic                                   in_held;
    logic                                   out_held;
    logic                                   duty_zero;
    logic                                   zero_mode;
    logic [p2pwm_pkg::BYTE_W:0]             in_word;
    logic [2*p2pwm_pkg::DUTY_W-1:0]         out_word;

    assign cfg_write = cfg_valid && cfg_ready;
    assign in_held   = in_valid && in_stall;
    assign out_held  = out_valid && out_stall;
    assign in_word   = {data_byte, end_of_data};
    assign out_word  = {left_duty, right_duty};
    assign duty_zero = (left_duty == '0) && (right_duty == '0);
    assign zero_mode = wide_trk_reg && big_range_trk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_trk_reg      <= 1'b1;
            stereo_trk_reg    <= 1'b1;
            big_range_trk_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == p2pwm_pkg::REG_SAMPLE_WIDTH)
                wide_trk_reg <= cfg_data[0];
            if (cfg_index == p2pwm_pkg::REG_STEREO)
                stereo_trk_reg <= cfg_data[0];
            if (cfg_index == p2pwm_pkg::REG_PWM_RANGE)
                big_range_trk_reg <= cfg_data[p2pwm_pkg::CFG_DATA_W-1];
        end
    end

    `P2PWM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_held, in_valid && $stable(in_word))
    `P2PWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid)
    `P2PWM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(out_word))
    `P2PWM_ASSERT_IMPLY(a_mono_equal, clk, rst_n, out_valid && !stereo_trk_reg, left_duty == right_duty)
    `P2PWM_ASSERT_IMPLY(a_big_range_zero, clk, rst_n, out_valid && zero_mode, duty_zero)

endmodule

bind pcm_to_pwm_sample_formatter_core p2pwm_checker u_p2pwm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_duty   (left_duty),
    .right_duty  (right_duty),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

@@ sim/tb_pcm_to_pwm_sample_formatter_core.sv @@
// ----------------------------------------------------------------------------
// tb_pcm_to_pwm_sample_formatter_core
// drives pcm bytes into the formatter and checks every left/right duty pair
// scoreboard predicts frame assembly, sign flip and range scaling
// modes and ranges change between idle phases, including mid-frame
// random idling on both sides plus two long output hold-offs
// ----------------------------------------------------------------------------
module tb_pcm_to_pwm_sample_formatter_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [p2pwm_pkg::DUTY_W-1:0] left;
        logic [p2pwm_pkg::DUTY_W-1:0] right;
    } duty_pair_t;

    class frame_duty_tracker;
        logic                               wide;
        logic                               stereo;
        logic [p2pwm_pkg::RANGE_W-1:0]      pwm_range;
        logic [1:0]                         phase;
        logic [p2pwm_pkg::BYTE_W-1:0]       low_hold;
        logic [p2pwm_pkg::DUTY_W-1:0]       left_hold;
        duty_pair_t                         expected_pairs[$];
        int                                 errors;
        int                                 bytes_taken;
        int                                 pairs_checked;
        int                                 reg_writes;

        function new();
            wide          = 1'b1;
            stereo        = 1'b1;
            pwm_range     = p2pwm_pkg::RESET_PWM_RANGE;
            phase         = '0;
            low_hold      = '0;
            left_hold     = '0;
            errors        = 0;
            bytes_taken   = 0;
            pairs_checked = 0;
            reg_writes    = 0;
        endfunction

        function void write_reg(logic [p2pwm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [p2pwm_pkg::CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                p2pwm_pkg::REG_SAMPLE_WIDTH: wide = data[0];
                p2pwm_pkg::REG_STEREO:       stereo = data[0];
                p2pwm_pkg::REG_PWM_RANGE:    pwm_range = data[p2pwm_pkg::RANGE_W-1:0];
                default:                     ;
            endcase
        endfunction

        function int unsigned duty_width_code();
            for (int c = 2; c < p2pwm_pkg::RANGE_SEARCH_TOP_DEF; c++)
                if (32'(pwm_range) < (32'd1 << c))
                    return c - 1;
            return 0;
        endfunction

        function logic [p2pwm_pkg::DUTY_W-1:0] fit_width(logic [p2pwm_pkg::SAMPLE_W-1:0] v);
            int unsigned w;
            int unsigned rb;
            logic [31:0] wv;
            logic [31:0] r;
            w  = wide ? 16 : 8;
            rb = duty_width_code();
            wv = 32'(v);
            if (w >= rb)
                r = wv >> (w - rb);
            else if (rb - w < 16)
                r = wv << (rb - w);
            else
                r = '0;
            return r[p2pwm_pkg::DUTY_W-1:0];
        endfunction

        function void take_byte(logic [p2pwm_pkg::BYTE_W-1:0] b, logic last);
            int unsigned flen;
            int unsigned ph;
            logic [p2pwm_pkg::SAMPLE_W-1:0] v;
            logic [p2pwm_pkg::DUTY_W-1:0] scaled;
            duty_pair_t pair;
            bytes_taken++;
            flen = (wide ? 2 : 1) * (stereo ? 2 : 1);
            ph = phase;
            if (ph >= flen)
                ph = 0;
            if (wide && (ph % 2 == 0)) begin
                low_hold = b;
            end else begin
                if (wide)
                    v = {b, low_hold} + p2pwm_pkg::SIGN_FLIP;
                else
                    v = {8'h00, b};
                scaled = fit_width(v);
                if (ph + 1 == flen) begin
                    pair.left  = stereo ? left_hold : scaled;
                    pair.right = scaled;
                    expected_pairs.push_back(pair);
                end else begin
                    left_hold = scaled;
                end
            end
            ph++;
            if (ph >= flen || last)
                ph = 0;
            phase = ph[1:0];
        endfunction

        function void check_pair(logic [p2pwm_pkg::DUTY_W-1:0] l,
                                 logic [p2pwm_pkg::DUTY_W-1:0] r);
            duty_pair_t exp_pair;
            pairs_checked++;
            if (expected_pairs.size() == 0) begin
                errors++;
                $display("%0t: unexpected duty pair left=%0d right=%0d", $time, l, r);
                return;
            end
            exp_pair = expected_pairs.pop_front();
            if (l !== exp_pair.left) begin
                errors++;
                $display("%0t: left_duty expected %0d actual %0d", $time, exp_pair.left, l);
            end
            if (r !== exp_pair.right) begin
                errors++;
                $display("%0t: right_duty expected %0d actual %0d", $time, exp_pair.right, r);
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic [p2pwm_pkg::BYTE_W-1:0]           data_byte = '0;
    logic                                   end_of_data = 1'b0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic [p2pwm_pkg::DUTY_W-1:0]           left_duty;
    logic [p2pwm_pkg::DUTY_W-1:0]           right_duty;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [p2pwm_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [p2pwm_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    frame_duty_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int long_hold_req = 0;
    int hold_left = 0;

    pcm_to_pwm_sample_formatter_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .end_of_data(end_of_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_duty  (left_duty),
        .right_duty (right_duty),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("pcm_to_pwm_sample_formatter_core: mismatch");
        $finish;
    end

    // output side stalls, long hold-off counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req > 0)
            begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_pair(left_duty, right_duty);
    end

    task automatic send_byte(input logic [p2pwm_pkg::BYTE_W-1:0] b, input logic last);
        bit ok;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_data <= last;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        while (!ok);
        tracker.take_byte(b, last);
    endtask

    task automatic write_reg(input logic [p2pwm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [p2pwm_pkg::CFG_DATA_W-1:0] data);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mode(input logic wide, input logic stereo, input logic [15:0] rng);
        settle_block();
        write_reg(p2pwm_pkg::REG_SAMPLE_WIDTH, {15'd0, wide});
        write_reg(p2pwm_pkg::REG_STEREO, {15'd0, stereo});
        write_reg(p2pwm_pkg::REG_PWM_RANGE, rng);
    endtask

    function automatic logic [15:0] pick_range();
        logic [15:0] edges[11] = '{16'd0, 16'd1, 16'd3, 16'd4, 16'd1023, 16'd1024,
                                   16'd16383, 16'd16384, 16'd32767, 16'd32768, 16'd65535};
        logic [16:0] pow;
        case ($urandom_range(3))
            0: return edges[$urandom_range(10)];
            1:
            begin
                pow = 17'd1 << $urandom_range(15);
                return 16'(pow - 17'($urandom_range(1)));
            end
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_bytes(input int n);
        logic [p2pwm_pkg::BYTE_W-1:0] b;
        logic [p2pwm_pkg::BYTE_W-1:0] corners[4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 85)
                b = 8'($urandom_range(255));
            else
                b = corners[$urandom_range(3)];
            send_byte(b, ($urandom_range(99) < 4));
        end
    endtask

    initial
    begin
        int sent;
        int n;
        @(posedge clk iff rst_n);
        send_idle_pct = 30;
        recv_idle_pct = 70;

        // reset mode, 16-bit stereo: full scale low and high, then a dropped partial frame
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h01, 1'b1);

        set_mode(1'b0, 1'b0, 16'd16384);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        set_mode(1'b0, 1'b0, 16'd65535);
        send_byte(8'hff, 1'b0);
        set_mode(1'b0, 1'b0, 16'd0);
        send_byte(8'hff, 1'b0);

        // mode change mid-frame, phase beyond the new frame length
        set_mode(1'b1, 1'b1, 16'd1024);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        set_mode(1'b0, 1'b0, 16'd1024);
        send_byte(8'h44, 1'b0);

        // high byte pairs with a stale low byte
        set_mode(1'b0, 1'b1, 16'd255);
        send_byte(8'hc3, 1'b0);
        set_mode(1'b1, 1'b0, 16'd255);
        send_byte(8'h9a, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            settle_block();
            case (p)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 530)
            begin
                set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), pick_range());
                if (sent == 0 && p != 1)
                    long_hold_req = 200;
                n = $urandom_range(10, 60);
                random_bytes(n);
                sent += n;
            end
        end

        settle_block();
        $display("run covered %0d bytes, %0d duty pairs, %0d register writes",
                 tracker.bytes_taken, tracker.pairs_checked, tracker.reg_writes);
        $display("modes: 8/16-bit, mono/stereo, ranges 0..65535, dropped and mid-frame cuts");
        if (tracker.errors == 0)
            $display("pcm_to_pwm_sample_formatter_core: match");
        else
            $display("pcm_to_pwm_sample_formatter_core: mismatch");
        $finish;
    end

endmodule
